// File: design/isf_pkg.sv
// Shared constants, types and helpers of the Ising lattice spin-flip block.
package isf_pkg;

   localparam int SIDE     = 64;
   localparam int COORD_W  = $clog2(SIDE);
   localparam int FIELD_W  = 6;
   localparam int FRAC_W   = 32;
   localparam int ENERGY_W = 15;
   localparam int MAGNET_W = 14;

   localparam logic signed [ENERGY_W-1:0] ENERGY_INIT = ENERGY_W'(-2 * SIDE * SIDE);
   localparam logic signed [MAGNET_W-1:0] MAGNET_INIT = MAGNET_W'(SIDE * SIDE);

   typedef logic [SIDE-1:0]    row_type;
   typedef logic [COORD_W-1:0] coord_type;

   typedef enum logic {
      CSR_THRESH_FOUR  = 1'b0,
      CSR_THRESH_EIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                        flip;
      logic signed [ENERGY_W-1:0]  energy_delta;
      logic signed [MAGNET_W-1:0]  magnet_delta;
      row_type                     new_row;
   } eval_type;

   // The side is a power of two, so wrapping a coordinate keeps its low bits.
   function automatic coord_type coord_of(input logic [FIELD_W-1:0] value);
      return COORD_W'(value);
   endfunction

endpackage

// File: design/isf_row_ram.sv
// Lattice store: one row of spins per word, one write and one registered read per cycle.
module isf_row_ram (
   input  logic              clock,
   input  logic              wr_en,
   input  isf_pkg::coord_type wr_addr,
   input  isf_pkg::row_type  wr_data,
   input  isf_pkg::coord_type rd_addr,
   output isf_pkg::row_type  rd_data
);
   import isf_pkg::*;

   row_type mem [SIDE];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/isf_flip_eval.sv
// Metropolis decision for one site from its row and the rows above and below.
module isf_flip_eval (
   input  isf_pkg::row_type             up_row,
   input  isf_pkg::row_type             down_row,
   input  isf_pkg::row_type             mid_row,
   input  isf_pkg::coord_type           col,
   input  logic [isf_pkg::FRAC_W-1:0]   rand_frac,
   input  logic [isf_pkg::FRAC_W-1:0]   thresh_four,
   input  logic [isf_pkg::FRAC_W-1:0]   thresh_eight,
   output isf_pkg::eval_type            result
);
   import isf_pkg::*;

   coord_type  left_col;
   coord_type  right_col;
   logic       spin;
   logic [2:0] up_count;
   logic [2:0] aligned;
   logic       accept;
   logic signed [ENERGY_W-1:0] delta;

   always_comb begin
      left_col  = col - 1'b1;
      right_col = col + 1'b1;
      spin      = mid_row[col];
      up_count  = 3'(up_row[col]) + 3'(down_row[col]) + 3'(mid_row[left_col])
                + 3'(mid_row[right_col]);
      aligned   = spin ? up_count : 3'd4 - up_count;
      case (aligned)
         3'd0:    delta = ENERGY_W'(-8);
         3'd1:    delta = ENERGY_W'(-4);
         3'd2:    delta = '0;
         3'd3:    delta = ENERGY_W'(4);
         default: delta = ENERGY_W'(8);
      endcase
      case (aligned)
         3'd3:    accept = rand_frac <= thresh_four;
         3'd4:    accept = rand_frac <= thresh_eight;
         default: accept = 1'b1;
      endcase
      result.flip         = accept;
      result.energy_delta = accept ? delta : '0;
      if (!accept) begin
         result.magnet_delta = '0;
      end else if (spin) begin
         result.magnet_delta = MAGNET_W'(-2);
      end else begin
         result.magnet_delta = MAGNET_W'(2);
      end
      result.new_row      = mid_row;
      result.new_row[col] = spin ^ accept;
   end

endmodule

// File: design/ising_metropolis_spin_flip.sv
// Top level of the two-dimensional Ising lattice Metropolis spin-flip block.
// A word is accepted at a rising edge with start high and busy low. Mode 0 runs one
// Metropolis trial at (req_site_row, req_site_col); mode 1 sets every spin up and
// restores the energy and magnetization totals.
// Each accepted word gives exactly one result word, shown for a single cycle with
// rsp_valid high; the receiver cannot stall, so results are never held.
// The lattice store has one registered read port: in a trial the rows above, below and
// at the site are read in turn, and the site row is written back at the edge that raises
// the strobe.
// Busy drops in the strobe cycle, so the next word is taken only once a trial's result is shown.
// An init word sweeps the store one row per cycle.
// After reset the same row sweep runs (busy high, no result), and the thresholds return
// to their default values.
// Threshold registers are written through the csr_ channel, which is always ready;
// they should be written only while busy is low.
module ising_metropolis_spin_flip (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_mode,
   input  logic [isf_pkg::FIELD_W-1:0]          req_site_col,
   input  logic [isf_pkg::FIELD_W-1:0]          req_site_row,
   input  logic [isf_pkg::FRAC_W-1:0]           req_rand_frac,
   output logic                                 rsp_valid,
   output logic                                 rsp_flipped,
   output logic signed [isf_pkg::ENERGY_W-1:0]  rsp_total_energy,
   output logic signed [isf_pkg::MAGNET_W-1:0]  rsp_total_magnetization,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_index,
   input  logic [isf_pkg::FRAC_W-1:0]           csr_data
);
   import isf_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_UP,
      ST_READ_DOWN,
      ST_EVAL
   } state_type;

   state_type                   state_ff, state_in;
   coord_type                   clr_row_ff, clr_row_in;
   logic                        clr_resp_ff, clr_resp_in;
   coord_type                   row_ff, row_in;
   coord_type                   col_ff, col_in;
   logic [FRAC_W-1:0]           rand_ff, rand_in;
   row_type                     up_row_ff, up_row_in;
   row_type                     down_row_ff, down_row_in;
   logic signed [ENERGY_W-1:0]  energy_ff, energy_in;
   logic signed [MAGNET_W-1:0]  magnet_ff, magnet_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_flipped_ff, rsp_flipped_in;
   logic [FRAC_W-1:0]           thresh_four_ff;
   logic [FRAC_W-1:0]           thresh_eight_ff;

   logic                        ram_wr_en;
   coord_type                   ram_wr_addr;
   row_type                     ram_wr_data;
   coord_type                   ram_rd_addr;
   row_type                     ram_rd_data;
   eval_type                    eval;

   isf_row_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   isf_flip_eval u_eval (
      .up_row       (up_row_ff),
      .down_row     (down_row_ff),
      .mid_row      (ram_rd_data),
      .col          (col_ff),
      .rand_frac    (rand_ff),
      .thresh_four  (thresh_four_ff),
      .thresh_eight (thresh_eight_ff),
      .result       (eval)
   );

   always_comb begin
      state_in       = state_ff;
      clr_row_in     = clr_row_ff;
      clr_resp_in    = clr_resp_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      rand_in        = rand_ff;
      up_row_in      = up_row_ff;
      down_row_in    = down_row_ff;
      energy_in      = energy_ff;
      magnet_in      = magnet_ff;
      rsp_valid_in   = 1'b0;
      rsp_flipped_in = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = clr_row_ff;
      ram_wr_data    = '1;
      ram_rd_addr    = row_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en  = 1'b1;
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == COORD_W'(SIDE - 1)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = clr_resp_ff;
               clr_resp_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            ram_rd_addr = coord_of(req_site_row) - 1'b1;
            if (start) begin
               row_in  = coord_of(req_site_row);
               col_in  = coord_of(req_site_col);
               rand_in = req_rand_frac;
               if (req_mode) begin
                  state_in    = ST_CLEAR;
                  clr_row_in  = '0;
                  clr_resp_in = 1'b1;
                  energy_in   = ENERGY_INIT;
                  magnet_in   = MAGNET_INIT;
               end else begin
                  state_in = ST_READ_UP;
               end
            end
         end
         ST_READ_UP: begin
            up_row_in   = ram_rd_data;
            ram_rd_addr = row_ff + 1'b1;
            state_in    = ST_READ_DOWN;
         end
         ST_READ_DOWN: begin
            down_row_in = ram_rd_data;
            ram_rd_addr = row_ff;
            state_in    = ST_EVAL;
         end
         ST_EVAL: begin
            ram_wr_en      = 1'b1;
            ram_wr_addr    = row_ff;
            ram_wr_data    = eval.new_row;
            energy_in      = energy_ff + eval.energy_delta;
            magnet_in      = magnet_ff + eval.magnet_delta;
            rsp_valid_in   = 1'b1;
            rsp_flipped_in = eval.flip;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_row_ff     <= '0;
         clr_resp_ff    <= 1'b0;
         energy_ff      <= ENERGY_INIT;
         magnet_ff      <= MAGNET_INIT;
         rsp_valid_ff   <= 1'b0;
         rsp_flipped_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_row_ff     <= clr_row_in;
         clr_resp_ff    <= clr_resp_in;
         energy_ff      <= energy_in;
         magnet_ff      <= magnet_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_flipped_ff <= rsp_flipped_in;
      end
      row_ff      <= row_in;
      col_ff      <= col_in;
      rand_ff     <= rand_in;
      up_row_ff   <= up_row_in;
      down_row_ff <= down_row_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_four_ff  <= FRAC_W'(581260610);
         thresh_eight_ff <= FRAC_W'(78665071);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_THRESH_FOUR:  thresh_four_ff  <= csr_data;
            CSR_THRESH_EIGHT: thresh_eight_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign busy                    = (state_ff != ST_IDLE);
   assign csr_ready               = 1'b1;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_flipped             = rsp_flipped_ff;
   assign rsp_total_energy        = energy_ff;
   assign rsp_total_magnetization = magnet_ff;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the Ising lattice Metropolis spin-flip block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import isf_pkg::*;

   localparam logic [FRAC_W-1:0] DEFAULT_FOUR  = 32'd581260610;
   localparam logic [FRAC_W-1:0] DEFAULT_EIGHT = 32'd78665071;
   localparam logic [FRAC_W-1:0] FRAC_MAX      = 32'hFFFF_FFFF;

   typedef struct {
      bit                         flipped;
      logic signed [ENERGY_W-1:0] energy;
      logic signed [MAGNET_W-1:0] magnet;
   } spin_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_mode = 1'b0;
   logic [FIELD_W-1:0] req_site_col = '0;
   logic [FIELD_W-1:0] req_site_row = '0;
   logic [FRAC_W-1:0] req_rand_frac = '0;
   logic rsp_valid;
   logic rsp_flipped;
   logic signed [ENERGY_W-1:0] rsp_total_energy;
   logic signed [MAGNET_W-1:0] rsp_total_magnetization;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [FRAC_W-1:0] csr_data = '0;

   // Predicted lattice, totals and thresholds.
   bit lattice [SIDE][SIDE];
   logic signed [ENERGY_W-1:0] energy_now;
   logic signed [MAGNET_W-1:0] magnet_now;
   logic [FRAC_W-1:0] thresh_four;
   logic [FRAC_W-1:0] thresh_eight;

   spin_outcome_type outcome_q[$];
   int error_count = 0;
   int words_checked = 0;
   int flips_seen = 0;
   int inits_sent = 0;
   int csr_writes = 0;
   int no_gap_left = 0;

   ising_metropolis_spin_flip DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_site_col(req_site_col),
      .req_site_row(req_site_row),
      .req_rand_frac(req_rand_frac),
      .rsp_valid(rsp_valid),
      .rsp_flipped(rsp_flipped),
      .rsp_total_energy(rsp_total_energy),
      .rsp_total_magnetization(rsp_total_magnetization),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void lattice_all_up();
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            lattice[r][c] = 1'b1;
         end
      end
      energy_now = ENERGY_W'(-2 * SIDE * SIDE);
      magnet_now = MAGNET_W'(SIDE * SIDE);
   endfunction

   function automatic int spin_val(int r, int c);
      return lattice[r % SIDE][c % SIDE] ? 1 : -1;
   endfunction

   function automatic spin_outcome_type metropolis_step(bit mode, bit [FIELD_W-1:0] col_f,
                                                        bit [FIELD_W-1:0] row_f,
                                                        bit [FRAC_W-1:0] frac);
      spin_outcome_type res;
      int c;
      int r;
      int s;
      int nsum;
      int de;
      bit accept;
      res.flipped = 1'b0;
      if (mode) begin
         lattice_all_up();
      end else begin
         c = col_f % SIDE;
         r = row_f % SIDE;
         s = spin_val(r, c);
         nsum = spin_val(r, c + SIDE - 1) + spin_val(r, c + 1)
              + spin_val(r + SIDE - 1, c) + spin_val(r + 1, c);
         de = 2 * s * nsum;
         if (de <= 0) accept = 1'b1;
         else if (de == 4) accept = (frac <= thresh_four);
         else accept = (frac <= thresh_eight);
         if (accept) begin
            lattice[r][c] = ~lattice[r][c];
            energy_now = energy_now + ENERGY_W'(de);
            magnet_now = magnet_now + MAGNET_W'((s > 0) ? -2 : 2);
            res.flipped = 1'b1;
         end
      end
      res.energy = energy_now;
      res.magnet = magnet_now;
      return res;
   endfunction

   // Sends one word after a random gap and records the predicted result.
   task automatic send_word(input bit mode, input bit [FIELD_W-1:0] col,
                            input bit [FIELD_W-1:0] row, input bit [FRAC_W-1:0] frac);
      int gap;
      gap = $urandom_range(0, 8);
      if (no_gap_left > 0) begin
         gap = 0;
         no_gap_left--;
      end
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_mode <= mode;
      req_site_col <= col;
      req_site_row <= row;
      req_rand_frac <= frac;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (mode) inits_sent++;
      outcome_q.push_back(metropolis_step(mode, col, row, frac));
   endtask

   task automatic trial(input int col, input int row, input bit [FRAC_W-1:0] frac);
      send_word(1'b0, FIELD_W'(col), FIELD_W'(row), frac);
   endtask

   // Holds off the sender until every result is in and the block is idle.
   task automatic quiesce();
      @(negedge clock);
      start <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_threshold(input csr_index_type idx, input bit [FRAC_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_THRESH_FOUR) thresh_four = value;
      else thresh_eight = value;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      spin_outcome_type want;
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: result word with nothing pending: flipped %0d energy %0d magnet %0d",
                     $time, rsp_flipped, rsp_total_energy, rsp_total_magnetization);
            error_count++;
         end else begin
            want = outcome_q.pop_front();
            words_checked++;
            if (want.flipped) flips_seen++;
            if (rsp_flipped !== want.flipped) begin
               $display("%0t: flipped expected %0d actual %0d",
                        $time, want.flipped, rsp_flipped);
               error_count++;
            end
            if (rsp_total_energy !== want.energy) begin
               $display("%0t: total_energy expected %0d actual %0d",
                        $time, want.energy, rsp_total_energy);
               error_count++;
            end
            if (rsp_total_magnetization !== want.magnet) begin
               $display("%0t: total_magnetization expected %0d actual %0d",
                        $time, want.magnet, rsp_total_magnetization);
               error_count++;
            end
         end
      end
   end

   task automatic test_reset_defaults();
      quiesce();
      trial(0, 0, DEFAULT_EIGHT + 1);
      trial(0, 0, DEFAULT_EIGHT);
      trial(0, 0, FRAC_MAX);
   endtask

   task automatic test_wrap_and_delta_cases();
      trial(63, 63, '0);
      trial(63, 0, DEFAULT_FOUR + 1);
      trial(63, 0, DEFAULT_FOUR);
      trial(63, 0, FRAC_MAX);
      trial(10, 10, '0);
      trial(12, 10, '0);
      trial(11, 10, FRAC_MAX);
      send_word(1'b1, 6'd63, 6'd63, FRAC_MAX);
      trial(0, 0, '0);
   endtask

   task automatic test_threshold_extremes();
      quiesce();
      write_threshold(CSR_THRESH_FOUR, '0);
      write_threshold(CSR_THRESH_EIGHT, '0);
      trial(5, 5, 32'd1);
      trial(5, 5, '0);
      trial(6, 5, 32'd1);
      trial(6, 5, '0);
      quiesce();
      write_threshold(CSR_THRESH_FOUR, FRAC_MAX);
      write_threshold(CSR_THRESH_EIGHT, FRAC_MAX);
      trial(20, 20, FRAC_MAX);
      trial(21, 20, FRAC_MAX);
      send_word(1'b0, '0, '0, FRAC_MAX);
   endtask

   // Random trials with occasional lattice inits, mostly in a small patch across the wrap corner so neighbors interact.
   task automatic random_phase(input int words);
      bit mode;
      bit [FIELD_W-1:0] col;
      bit [FIELD_W-1:0] row;
      bit [FRAC_W-1:0] frac;
      for (int n = 0; n < words; n++) begin
         if ($urandom_range(0, 39) == 0) no_gap_left = 20;
         mode = ($urandom_range(0, 99) < 2);
         if ($urandom_range(0, 99) < 65) begin
            col = FIELD_W'(62 + $urandom_range(0, 3));
            row = FIELD_W'(62 + $urandom_range(0, 3));
         end else begin
            col = FIELD_W'($urandom_range(0, 63));
            row = FIELD_W'($urandom_range(0, 63));
         end
         case ($urandom_range(0, 9))
            0: frac = '0;
            1: frac = FRAC_MAX;
            2: frac = thresh_four + $urandom_range(0, 2) - 1;
            3: frac = thresh_eight + $urandom_range(0, 2) - 1;
            default: frac = $urandom;
         endcase
         send_word(mode, col, row, frac);
      end
   endtask

   task automatic test_random_trials();
      bit [FRAC_W-1:0] four_set [5];
      bit [FRAC_W-1:0] eight_set [5];
      four_set = '{32'h2BE0_0000, '0, FRAC_MAX, $urandom, FRAC_MAX};
      eight_set = '{32'h07D0_0000, '0, FRAC_MAX, $urandom, '0};
      for (int p = 0; p < 5; p++) begin
         quiesce();
         write_threshold(CSR_THRESH_FOUR, four_set[p]);
         write_threshold(CSR_THRESH_EIGHT, eight_set[p]);
         random_phase(168);
      end
   endtask

   initial begin
      lattice_all_up();
      thresh_four = DEFAULT_FOUR;
      thresh_eight = DEFAULT_EIGHT;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_wrap_and_delta_cases();
      test_threshold_extremes();
      test_random_trials();
      quiesce();
      repeat (SIDE + 8) @(posedge clock);
      $display("Checked %0d result words, %0d of them flips, across %0d lattice inits.",
               words_checked, flips_seen, inits_sent);
      $display("Thresholds were rewritten %0d times, including zero and full scale.",
               csr_writes);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches found.", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d result words still pending.", outcome_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
